// File: rtl/core/tfcm_pkg.sv
// ----------------------------------------------------------------------------
// tfcm_pkg
// Shared types, constants and the elaboration-time hue functions of the
// thermal false-colour map.
// ----------------------------------------------------------------------------
package tfcm_pkg;

   localparam int TEMP_W = 12;
   localparam int CHAN_W = 8;
   localparam int SECT_W = 3;
   localparam int REM_W  = 6;

   // Hue sectors of sixty degrees each.
   localparam logic [SECT_W-1:0] SECT_RED_YELLOW    = 3'd0;
   localparam logic [SECT_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
   localparam logic [SECT_W-1:0] SECT_GREEN_CYAN    = 3'd2;
   localparam logic [SECT_W-1:0] SECT_CYAN_BLUE     = 3'd3;
   localparam logic [SECT_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;
   localparam logic [SECT_W-1:0] SECT_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic [SECT_W-1:0] sector;
      logic [REM_W-1:0]  rem;
   } hue_entry_type;

   localparam longint unsigned Q24_ONE   = 64'd1 << 24;
   localparam longint unsigned Q30_ONE   = 64'd1 << 30;
   localparam longint unsigned LOG2E_Q24 = 64'd24204406;
   localparam longint          Q24_SIGNED = 64'sd16777216;

   function automatic longint unsigned isqrt64(longint unsigned x_arg);
      longint unsigned x;
      longint unsigned r;
      longint unsigned bitv;
      x    = x_arg;
      r    = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Base-two logarithm in Q24, by normalisation and repeated squaring.
   function automatic longint log2_q24(longint unsigned v);
      longint unsigned n;
      longint unsigned m;
      longint unsigned frac;
      n    = 64'd0;
      frac = 64'd0;
      while (n < 64'd30 && (v >> (n + 64'd1)) != 64'd0) n = n + 64'd1;
      m = v << (64'd30 - n);
      for (int i = 0; i < 24; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            m    = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return longint'((n << 24) | frac);
   endfunction

   // Two to a Q24 fraction, as a Q30 product of successive square roots of two.
   function automatic longint unsigned exp2_frac_q30(longint unsigned f);
      longint unsigned c;
      longint unsigned acc;
      c   = 64'd2 << 30;
      acc = Q30_ONE;
      for (int i = 1; i <= 24; i++) begin
         c = isqrt64(c << 30);
         if (((f >> (24 - i)) & 64'd1) != 64'd0) acc = (acc * c) >> 30;
      end
      return acc;
   endfunction

   function automatic int unsigned hue_of(longint unsigned d, int unsigned frac_bits);
      longint          a;
      longint          b;
      longint          bi;
      longint unsigned bf;
      longint unsigned p;
      longint unsigned y;
      longint unsigned z;
      longint unsigned zi;
      longint unsigned zf;
      longint unsigned mant;
      longint unsigned sh;
      longint unsigned hue;
      longint unsigned bsh;
      if (d == 64'd0) return 300;
      a = log2_q24(d) - log2_q24(64'd21) - longint'(frac_bits) * Q24_SIGNED;
      b = a * 64'sd13 / 64'sd5;
      if (b >= 0) bi = b / Q24_SIGNED;
      else        bi = -((-b + Q24_SIGNED - 64'sd1) / Q24_SIGNED);
      bf = unsigned'(b - bi * Q24_SIGNED);
      p  = exp2_frac_q30(bf);
      if (bi > 64'sd6) bi = 64'sd6;
      bsh = unsigned'(64'sd6 - bi);
      y   = (bsh >= 64'd63) ? 64'd0 : (p >> bsh);
      z   = (y * LOG2E_Q24) >> 24;
      zi  = z >> 24;
      zf  = z & (Q24_ONE - 64'd1);
      if (zf == 64'd0) begin
         mant = Q30_ONE;
         sh   = 64'd30 + zi;
      end else begin
         mant = exp2_frac_q30(Q24_ONE - zf);
         sh   = 64'd31 + zi;
      end
      if (sh >= 64'd40) return 0;
      hue = (64'd300 * mant) >> sh;
      return (hue > 64'd300) ? 300 : 32'(hue);
   endfunction

   function automatic hue_entry_type hue_entry(int unsigned d, int unsigned frac_bits);
      hue_entry_type e;
      int unsigned   h;
      h        = hue_of(64'(d), frac_bits);
      e.sector = SECT_W'(h / 60);
      e.rem    = REM_W'(h % 60);
      return e;
   endfunction

endpackage

// File: rtl/core/tfcm_req_if.sv
// ----------------------------------------------------------------------------
// tfcm_req_if
// Input channel: one temperature reading and its coverage flag per transaction.
// ----------------------------------------------------------------------------
interface tfcm_req_if;
   import tfcm_pkg::*;

   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temperature;
   logic              has_readings;

   modport source (output valid, output temperature, output has_readings, input ready);
   modport sink   (input valid, input temperature, input has_readings, output ready);

endinterface

// File: rtl/core/tfcm_rsp_if.sv
// ----------------------------------------------------------------------------
// tfcm_rsp_if
// Result channel: one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface tfcm_rsp_if;
   import tfcm_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// File: rtl/core/thermal_false_color_map.sv
// ----------------------------------------------------------------------------
// thermal_false_color_map
// Turns a fixed-point temperature into a false-colour RGB pixel.
// ----------------------------------------------------------------------------
// One pixel is accepted and one delivered per clock while the result channel
// accepts; each passes the clamp, table, product and output registers. The
// temperature is clamped to 10..80 degrees and indexes a hue table of
// 70*2^TEMP_FRAC_BITS+1 entries, computed at elaboration and read through a
// registered port, which stores the hue sector and the remainder within it.
// Readings below ten degrees dim the value channel linearly towards zero, and
// a pixel without readings is black. Each stage holds its transaction while
// the stage after it is full and stalled, so the input keeps being taken
// until all four stages are occupied.
// ----------------------------------------------------------------------------
module thermal_false_color_map #(
   parameter int TEMP_FRAC_BITS = 4
) (
   input  logic  clock,
   input  logic  reset,
   tfcm_req_if.sink   req_chan,
   tfcm_rsp_if.source rsp_chan
);
   import tfcm_pkg::*;

   localparam int LO     = 10 * (2 ** TEMP_FRAC_BITS);
   localparam int HI     = 80 * (2 ** TEMP_FRAC_BITS);
   localparam int DEPTH  = HI - LO + 1;
   localparam int DW     = $clog2(DEPTH);
   localparam int HW     = $clog2(HI + 1);
   localparam int XW     = (HW > TEMP_W) ? HW : TEMP_W;
   localparam int PW     = 22;
   localparam int QW     = 11;
   localparam int SH_RF  = TEMP_FRAC_BITS + 3;
   localparam int SH_FUL = TEMP_FRAC_BITS + 1;

   // Stage valid bits and the ready chain.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_chan.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_chan.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: clamp and table index. The dimming operand is the reading
   // itself below ten degrees and the threshold otherwise, which gives full
   // value through the same arithmetic.
   logic [XW-1:0]     temp_x;
   logic              below;
   logic              above;
   logic [XW-1:0]     clamped;
   logic [DW-1:0]     idx_in, idx_ff;
   logic [TEMP_W-1:0] tv_in, tv1_ff;
   logic              has1_ff;

   assign temp_x  = XW'(req_chan.temperature);
   assign below   = temp_x < XW'(LO);
   assign above   = temp_x > XW'(HI);
   assign clamped = below ? XW'(LO) : (above ? XW'(HI) : temp_x);
   assign idx_in  = DW'(clamped - XW'(LO));
   assign tv_in   = below ? req_chan.temperature : TEMP_W'(LO);

   always_ff @(posedge clock) begin
      if (req_chan.valid && rdy1) begin
         idx_ff  <= idx_in;
         tv1_ff  <= tv_in;
         has1_ff <= req_chan.has_readings;
      end
   end

   // Stage 2: hue table read.
   hue_entry_type     hue2;
   logic [TEMP_W-1:0] tv2_ff;
   logic              has2_ff;

   tfcm_hue_rom #(
      .FRAC_BITS (TEMP_FRAC_BITS)
   ) u_hue_rom (
      .clock   (clock),
      .rd_en   (v1_ff && rdy2),
      .rd_addr (idx_ff),
      .rd_data (hue2)
   );

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         tv2_ff  <= tv1_ff;
         has2_ff <= has1_ff;
      end
   end

   // Stage 3: products 17*v*r, 17*v*(60-r) and 51*v, where 255/60 = 17/4.
   logic [PW-1:0]     tv_w;
   logic [PW-1:0]     rise_p_in, fall_p_in, full_p_in;
   logic [PW-1:0]     rise_p_ff, fall_p_ff, full_p_ff;
   logic [SECT_W-1:0] sect3_ff;
   logic              has3_ff;

   assign tv_w      = PW'(tv2_ff);
   assign rise_p_in = tv_w * PW'(hue2.rem) * PW'(17);
   assign fall_p_in = tv_w * PW'(REM_W'(60) - hue2.rem) * PW'(17);
   assign full_p_in = tv_w * PW'(51);

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         rise_p_ff <= rise_p_in;
         fall_p_ff <= fall_p_in;
         full_p_ff <= full_p_in;
         sect3_ff  <= hue2.sector;
         has3_ff   <= has2_ff;
      end
   end

   // Stage 4: remaining division by five through a reciprocal that is exact
   // for quotients of the size that can occur here, then channel selection.
   logic [QW-1:0]      rise_x, fall_x;
   logic [QW+13-1:0]   rise_m, fall_m;
   logic [CHAN_W-1:0]  rise_c, fall_c, full_c;
   logic [CHAN_W-1:0]  red_in, green_in, blue_in;
   logic [CHAN_W-1:0]  red_ff, green_ff, blue_ff;

   assign rise_x = QW'(rise_p_ff >> SH_RF);
   assign fall_x = QW'(fall_p_ff >> SH_RF);
   assign rise_m = (QW + 13)'(rise_x) * (QW + 13)'(6554);
   assign fall_m = (QW + 13)'(fall_x) * (QW + 13)'(6554);
   assign rise_c = CHAN_W'(rise_m >> 15);
   assign fall_c = CHAN_W'(fall_m >> 15);
   assign full_c = CHAN_W'(full_p_ff >> SH_FUL);

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (has3_ff) begin
         case (sect3_ff)
            SECT_YELLOW_GREEN: begin
               red_in   = fall_c;
               green_in = full_c;
            end
            SECT_GREEN_CYAN: begin
               green_in = full_c;
               blue_in  = rise_c;
            end
            SECT_CYAN_BLUE: begin
               green_in = fall_c;
               blue_in  = full_c;
            end
            SECT_BLUE_MAGENTA: begin
               red_in   = rise_c;
               blue_in  = full_c;
            end
            SECT_MAGENTA_RED: begin
               red_in   = full_c;
               blue_in  = fall_c;
            end
            default: begin
               red_in   = full_c;
               green_in = rise_c;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && rdy4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_chan.valid = v4_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

endmodule

// File: rtl/core/tfcm_hue_rom.sv
// ----------------------------------------------------------------------------
// tfcm_hue_rom
// Hue lookup indexed by clamped temperature above ten degrees, built at
// elaboration, with a registered read port.
// ----------------------------------------------------------------------------
module tfcm_hue_rom #(
   parameter int FRAC_BITS = 4
) (
   input  logic                                       clock,
   input  logic                                       rd_en,
   input  logic [$clog2(70*(2**FRAC_BITS)+1)-1:0]     rd_addr,
   output tfcm_pkg::hue_entry_type                    rd_data
);
   import tfcm_pkg::*;

   localparam int DEPTH = 70 * (2 ** FRAC_BITS) + 1;

   hue_entry_type rom_w [DEPTH];
   hue_entry_type data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam hue_entry_type ENTRY = hue_entry(i, FRAC_BITS);
      assign rom_w[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom_w[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermal false-colour map. A short table of
// readings covers the clamping limits, the dimmed range, the magenta end of
// the hue ramp and black pixels. About 1150 random readings then follow under
// three idling patterns. Each pixel is compared with its listed value, if any,
// or an independent fixed-point model of the hue ramp and HSV to RGB conversion.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tfcm_pkg::*;

   localparam int FRAC_BITS    = 4;
   localparam int T_LOW        = 10 << FRAC_BITS;
   localparam int T_HIGH       = 80 << FRAC_BITS;
   localparam int HUE_ENTRIES  = T_HIGH - T_LOW + 1;
   localparam int RANDOM_ITEMS = 1150;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct {
      logic [TEMP_W-1:0] temperature;
      logic              has_readings;
      bit                known;
      pixel_type         pixel;
   } reading_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfcm_req_if req_bus ();
   tfcm_rsp_if rsp_bus ();

   thermal_false_color_map #(
      .TEMP_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #6 clock = ~clock;

   longint unsigned sqrt2_roots [1:24];
   int unsigned     hue_rom [0:HUE_ENTRIES-1];
   pixel_type       expected_pixels [$];
   reading_row_type reading_table [$];

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int          mismatch_count    = 0;
   int          pixels_compared   = 0;
   int          readings_sent     = 0;
   int          dark_count        = 0;
   int          dimmed_count      = 0;
   int          hot_count         = 0;

   function automatic longint unsigned int_sqrt(longint unsigned radicand);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned probe;
      rest  = radicand;
      root  = 64'd0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 64'd0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Base-two logarithm in Q24: integer part from the leading one, fraction
   // by repeated squaring of the normalised mantissa.
   function automatic longint lg2_q24(longint unsigned v);
      longint unsigned msb;
      longint unsigned mant;
      longint unsigned frac;
      msb  = 64'd0;
      frac = 64'd0;
      while (msb < 64'd30 && (v >> (msb + 64'd1)) != 64'd0) msb = msb + 64'd1;
      mant = v << (64'd30 - msb);
      repeat (24) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd2 << 30)) begin
            mant = mant >> 1;
            frac = frac | 64'd1;
         end
      end
      return longint'((msb << 24) | frac);
   endfunction

   function automatic longint unsigned pow2_frac_q30(longint unsigned f);
      longint unsigned acc;
      acc = Q30_ONE;
      for (int i = 1; i <= 24; i++) begin
         if (f[24-i]) acc = (acc * sqrt2_roots[i]) >> 30;
      end
      return acc;
   endfunction

   // Hue for a temperature offset above ten degrees, 300 at zero falling
   // towards red as the offset grows.
   function automatic int unsigned hue_for_offset(longint unsigned offset);
      longint          a;
      longint          b;
      longint          whole;
      longint unsigned p;
      longint unsigned y;
      longint unsigned z;
      longint unsigned z_int;
      longint unsigned z_frac;
      longint unsigned mant;
      longint unsigned shift;
      longint unsigned h;
      if (offset == 64'd0) return 300;
      a     = lg2_q24(offset) - lg2_q24(64'd21) - (longint'(FRAC_BITS) <<< 24);
      b     = a * 13 / 5;
      whole = b >>> 24;
      p     = pow2_frac_q30(unsigned'(b - (whole <<< 24)));
      if (whole > 6) whole = 6;
      y      = (6 - whole >= 63) ? 64'd0 : (p >> (6 - whole));
      z      = (y * LOG2E_Q24) >> 24;
      z_int  = z >> 24;
      z_frac = z & (Q24_ONE - 64'd1);
      if (z_frac == 64'd0) begin
         mant  = Q30_ONE;
         shift = 64'd30 + z_int;
      end else begin
         mant  = pow2_frac_q30(Q24_ONE - z_frac);
         shift = 64'd31 + z_int;
      end
      if (shift >= 64'd40) return 0;
      h = (64'd300 * mant) >> shift;
      return (h > 64'd300) ? 300 : 32'(h);
   endfunction

   function automatic pixel_type colour_of(logic [TEMP_W-1:0] temp, logic has);
      logic [TEMP_W-1:0] clamped;
      logic [SECT_W-1:0] sector;
      int unsigned       hue;
      longint unsigned   rem;
      longint unsigned   vnum;
      longint unsigned   vden;
      longint unsigned   full;
      longint unsigned   rise;
      longint unsigned   fall;
      pixel_type         px;
      if (!has) return '0;
      clamped = (temp < T_LOW) ? TEMP_W'(T_LOW) : ((temp > T_HIGH) ? TEMP_W'(T_HIGH) : temp);
      hue     = hue_rom[clamped - T_LOW];
      sector  = SECT_W'(hue / 60);
      rem     = hue % 60;
      if (temp < T_LOW) begin
         vnum = temp;
         vden = T_LOW;
      end else begin
         vnum = 1;
         vden = 1;
      end
      full = (255 * vnum) / vden;
      rise = (255 * vnum * rem) / (60 * vden);
      fall = (255 * vnum * (60 - rem)) / (60 * vden);
      case (sector)
         SECT_YELLOW_GREEN: px = {CHAN_W'(fall), CHAN_W'(full), CHAN_W'(0)};
         SECT_GREEN_CYAN:   px = {CHAN_W'(0), CHAN_W'(full), CHAN_W'(rise)};
         SECT_CYAN_BLUE:    px = {CHAN_W'(0), CHAN_W'(fall), CHAN_W'(full)};
         SECT_BLUE_MAGENTA: px = {CHAN_W'(rise), CHAN_W'(0), CHAN_W'(full)};
         SECT_MAGENTA_RED:  px = {CHAN_W'(full), CHAN_W'(0), CHAN_W'(fall)};
         // Red to yellow.
         default:           px = {CHAN_W'(full), CHAN_W'(rise), CHAN_W'(0)};
      endcase
      return px;
   endfunction

   task automatic add_row(int temp, bit has, bit known, int r, int g, int b);
      reading_row_type row;
      row.temperature  = TEMP_W'(temp);
      row.has_readings = has;
      row.known        = known;
      row.pixel        = {CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)};
      reading_table.insert(reading_table.size(), row);
   endtask

   task automatic note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
   endtask

   task automatic send_reading(logic [TEMP_W-1:0] temp, logic has, bit known, pixel_type px);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.temperature  <= temp;
      req_bus.has_readings <= has;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_pixels.insert(expected_pixels.size(), known ? px : colour_of(temp, has));
      readings_sent++;
      if (!has) dark_count++;
      else if (temp < T_LOW) dimmed_count++;
      else if (temp > T_HIGH) hot_count++;
   endtask

   task automatic send_random_reading();
      logic [TEMP_W-1:0] temp;
      int unsigned       pick;
      pick = $urandom_range(99);
      if (pick < 50) temp = TEMP_W'($urandom_range(T_HIGH, T_LOW));
      else if (pick < 70) temp = TEMP_W'($urandom_range(T_LOW - 1, 0));
      else if (pick < 85) temp = TEMP_W'($urandom_range(4095, T_HIGH + 1));
      else temp = TEMP_W'($urandom());
      send_reading(temp, $urandom_range(99) >= 8, 1'b0, '0);
   endtask

   // The sender holds off here until every pixel in flight has been checked.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.red, rsp_bus.green, rsp_bus.blue};
         if (expected_pixels.size() == 0) begin
            note_failure($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
                                   got.red, got.green, got.blue));
         end else begin
            want = expected_pixels.pop_front();
            pixels_compared++;
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
               note_failure($sformatf("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                      pixels_compared, want.red, want.green, want.blue,
                                      got.red, got.green, got.blue));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      longint unsigned c;
      req_bus.valid        <= 1'b0;
      req_bus.temperature  <= '0;
      req_bus.has_readings <= 1'b0;

      c = 64'd2 << 30;
      for (int i = 1; i <= 24; i++) begin
         c              = int_sqrt(c << 30);
         sqrt2_roots[i] = c;
      end
      for (int d = 0; d < HUE_ENTRIES; d++) hue_rom[d] = hue_for_offset(d);

      // Black, red beyond the hot limit, magenta at ten degrees and the
      // dimmed magenta below it can all be read straight off the mapping.
      add_row(0,      0, 1,   0, 0,   0);
      add_row(4095,   0, 1,   0, 0,   0);
      add_row(4095,   1, 1, 255, 0,   0);
      add_row(T_HIGH, 1, 1, 255, 0,   0);
      add_row(T_LOW,  1, 1, 255, 0, 255);
      add_row(0,      1, 1,   0, 0,   0);
      add_row(1,      1, 1,   1, 0,   1);
      add_row(2,      1, 1,   3, 0,   3);
      add_row(80,     1, 1, 127, 0, 127);
      add_row(159,    1, 1, 253, 0, 253);
      add_row(161,    1, 0, 0, 0, 0);
      add_row(176,    1, 0, 0, 0, 0);
      add_row(200,    1, 0, 0, 0, 0);
      add_row(240,    1, 0, 0, 0, 0);
      add_row(320,    1, 0, 0, 0, 0);
      add_row(400,    1, 0, 0, 0, 0);
      add_row(480,    1, 0, 0, 0, 0);
      add_row(560,    1, 0, 0, 0, 0);
      add_row(640,    1, 0, 0, 0, 0);
      add_row(800,    1, 0, 0, 0, 0);
      add_row(960,    1, 0, 0, 0, 0);
      add_row(1279,   1, 0, 0, 0, 0);
      add_row(1281,   1, 0, 0, 0, 0);
      add_row('h555,  1, 0, 0, 0, 0);
      add_row('hAAA,  1, 0, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 29;
      receiver_idle_pct = 79;
      foreach (reading_table[i]) begin
         send_reading(reading_table[i].temperature, reading_table[i].has_readings,
                      reading_table[i].known, reading_table[i].pixel);
      end
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 29;
               receiver_idle_pct = 79;
            end
            1: begin
               sender_idle_pct   = 79;
               receiver_idle_pct = 29;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random_reading();
         drain();
      end

      repeat (10) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         note_failure($sformatf("%0d pixels never arrived", expected_pixels.size()));
      end

      $display("Sent %0d readings: %0d without readings, %0d dimmed below 10 C, %0d above 80 C.",
               readings_sent, dark_count, dimmed_count, hot_count);
      $display("Compared %0d pixels under three idling patterns; %0d failures.",
               pixels_compared, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/tfcm_pkg.sv
rtl/core/tfcm_req_if.sv
rtl/core/tfcm_rsp_if.sv
rtl/core/tfcm_hue_rom.sv
rtl/core/thermal_false_color_map.sv
bench/tb_top.sv
